FILE: rtl/refault_frequency_tracker_assert.svh
// Assertion macros for the refault frequency tracker.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef REFAULT_FREQUENCY_TRACKER_ASSERT_SVH
`define REFAULT_FREQUENCY_TRACKER_ASSERT_SVH
`ifndef SYNTHESIS
`define RFT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define RFT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define RFT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define RFT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

FILE: rtl/rft_pkg.sv
// Shared constants, codes and controller/datapath interface types of the tracker.
// No dependencies.
package rft_pkg;

    localparam int OWNER_SLOTS     = 16;
    localparam int ADDRESS_ENTRIES = 256;
    localparam int COUNT_LIMIT     = 256;

    localparam int OWNER_W = (OWNER_SLOTS > 1) ? $clog2(OWNER_SLOTS) : 1;
    localparam int ENTRY_W = (ADDRESS_ENTRIES > 1) ? $clog2(ADDRESS_ENTRIES) : 1;
    localparam int ACC_W   = $clog2(ADDRESS_ENTRIES + 1);

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef enum logic [2:0] {
        ST_COUNTED      = 3'd0,
        ST_IGNORED      = 3'd1,
        ST_OWNER_FULL   = 3'd2,
        ST_ADDR_FULL    = 3'd3,
        ST_QUERY_OK     = 3'd4,
        ST_OWNER_UNKNOWN = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE, S_OWN, S_ENT, S_DRAIN, S_DECIDE, S_FIN
    } state_t;

    typedef struct packed {
        logic    load;
        logic    own_step;
        logic    ent_step;
        logic    commit;
        logic    out_load;
        status_t status;
    } cmd_t;

    typedef struct packed {
        logic is_query;
        logic is_major;
        logic own_last;
        logic own_hit;
        logic own_free;
        logic ent_last;
        logic ent_hit;
        logic ent_free;
        logic out_free;
    } sts_t;

    typedef struct packed {
        logic [63:0]        addr;
        logic [OWNER_W-1:0] owner;
        logic [31:0]        count;
    } entry_t;

endpackage

FILE: rtl/refault_frequency_tracker.sv
// Top level of the refault frequency tracker: joins controller and datapath.
// Depends on rft_pkg, rft_ctrl and rft_datapath.
//
// Usage: each request on the slave channel is one event. s_tuser carries the
// opcode (bit 0: 0 record, 1 query) and the major-fault flag (bit 1). s_tdata
// carries owner_id, page_addr and bin_index. Every request yields exactly one
// result on the master channel: m_tuser is the status, m_tdata the counts.
// A minor-fault record skips both scans and ends as ignored. A major-fault
// record or a query scans the owner table, one slot a cycle, then the entry
// memory, one entry a cycle through its single read port, whose read is
// registered, then decides and loads the result. An unknown owner on a query,
// or a full owner table on a record, ends right after the owner scan. Queries
// count the matching entries during the scan, so a histogram bin is derived
// from the entry memory rather than stored. One request is in flight at a time;
// s_tready is high only while the block is waiting for a request.
// Reset clears the owner and entry valid flags at once; no clearing pass runs.
// When the receiver stalls, the finished result holds in the output register
// and the next request is processed up to the point of delivering its result.
module refault_frequency_tracker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,   // owner_id[63:0], page_addr[127:64], bin_index[136:128]
    input  logic [1:0]   s_tuser,   // opcode[0], is_major[1]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,   // new_count[31:0], owner_created[32],
                                    // address_created[33], bin_value[65:34], has_repeats[66]
    output logic [2:0]   m_tuser    // status[2:0]
);

    rft_pkg::cmd_t cmd;
    rft_pkg::sts_t sts;

    rft_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rft_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

FILE: rtl/rft_ctrl.sv
// Sequencing state machine of the tracker: owner scan, entry scan, update, result.
// Depends on rft_pkg.
module rft_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  rft_pkg::sts_t  sts,
    output rft_pkg::cmd_t  cmd
);

    rft_pkg::state_t  state_reg, state_next;
    rft_pkg::status_t status_reg, status_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= rft_pkg::S_IDLE;
            status_reg <= rft_pkg::ST_COUNTED;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        status_next = status_reg;
        cmd         = '0;
        cmd.status  = status_reg;
        s_tready    = 1'b0;
        case (state_reg)
            rft_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = rft_pkg::S_OWN;
                end
            end
            rft_pkg::S_OWN: begin
                if (!sts.is_query && !sts.is_major) begin
                    status_next = rft_pkg::ST_IGNORED;
                    state_next  = rft_pkg::S_FIN;
                end else begin
                    cmd.own_step = 1'b1;
                    if (sts.own_last) state_next = rft_pkg::S_ENT;
                end
            end
            rft_pkg::S_ENT: begin
                if (sts.is_query && !sts.own_hit) begin
                    status_next = rft_pkg::ST_OWNER_UNKNOWN;
                    state_next  = rft_pkg::S_FIN;
                end else if (!sts.is_query && !sts.own_hit && !sts.own_free) begin
                    status_next = rft_pkg::ST_OWNER_FULL;
                    state_next  = rft_pkg::S_FIN;
                end else begin
                    cmd.ent_step = 1'b1;
                    if (sts.ent_last) state_next = rft_pkg::S_DRAIN;
                end
            end
            rft_pkg::S_DRAIN: begin
                state_next = rft_pkg::S_DECIDE;
            end
            rft_pkg::S_DECIDE: begin
                state_next = rft_pkg::S_FIN;
                if (sts.is_query) begin
                    status_next = rft_pkg::ST_QUERY_OK;
                end else if (sts.ent_hit || sts.ent_free) begin
                    cmd.commit  = 1'b1;
                    status_next = rft_pkg::ST_COUNTED;
                end else begin
                    status_next = rft_pkg::ST_ADDR_FULL;
                end
            end
            rft_pkg::S_FIN: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = rft_pkg::S_IDLE;
                end
            end
            default: state_next = rft_pkg::S_IDLE;
        endcase
    end

endmodule

FILE: rtl/rft_datapath.sv
// Owner table, entry memory, scan comparators and the result register of the tracker.
// Depends on rft_pkg and refault_frequency_tracker_assert.svh.
`include "refault_frequency_tracker_assert.svh"
module rft_datapath (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [143:0]   s_tdata,
    input  logic [1:0]     s_tuser,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [71:0]    m_tdata,
    output logic [2:0]     m_tuser,
    input  rft_pkg::cmd_t  cmd,
    output rft_pkg::sts_t  sts
);

    localparam logic [rft_pkg::OWNER_W-1:0] OWN_LAST =
        rft_pkg::OWNER_W'(rft_pkg::OWNER_SLOTS - 1);
    localparam logic [rft_pkg::ENTRY_W-1:0] ENT_LAST =
        rft_pkg::ENTRY_W'(rft_pkg::ADDRESS_ENTRIES - 1);
    localparam logic [31:0] LIMIT = 32'(rft_pkg::COUNT_LIMIT);

    // Request registers.
    logic        op_reg, major_reg;
    logic [63:0] id_reg, addr_reg;
    logic [8:0]  bin_reg;

    logic [63:0] owner_key_reg [rft_pkg::OWNER_SLOTS];
    logic [rft_pkg::OWNER_SLOTS-1:0]     owner_valid_reg;
    logic [rft_pkg::ADDRESS_ENTRIES-1:0] entry_valid_reg;
    rft_pkg::entry_t entry_mem [rft_pkg::ADDRESS_ENTRIES];

    logic [rft_pkg::OWNER_W-1:0] oidx_reg, oslot_reg, ofree_slot_reg;
    logic                        ohit_reg, ofree_reg;
    logic [rft_pkg::ENTRY_W-1:0] eidx_reg, pidx_reg, ehit_idx_reg, efree_idx_reg;
    logic                        pval_reg, pvalid_reg, ehit_reg, efree_reg;
    rft_pkg::entry_t             rd_reg;
    logic [31:0]                 ecount_reg, newcnt_reg;
    logic [rft_pkg::ACC_W-1:0]   acc_reg;
    logic                        rep_reg;

    logic        out_valid_reg;
    logic [71:0] out_data_reg;
    logic [2:0]  out_user_reg;

    logic [rft_pkg::OWNER_W-1:0] cur_slot;
    logic                        own_match, addr_match, bin_match;
    logic [rft_pkg::ENTRY_W-1:0] wr_idx;
    logic [31:0]                 inc_count;

    assign cur_slot   = ohit_reg ? oslot_reg : ofree_slot_reg;
    assign own_match  = pvalid_reg && (rd_reg.owner == cur_slot);
    assign addr_match = own_match && (rd_reg.addr == addr_reg);
    // The top bin collects every count at or above the limit; bin zero is always empty.
    assign bin_match  = ({23'd0, bin_reg} < LIMIT) ? (rd_reg.count == {23'd0, bin_reg})
                      : ({23'd0, bin_reg} == LIMIT) ? (rd_reg.count >= LIMIT) : 1'b0;
    assign wr_idx     = ehit_reg ? ehit_idx_reg : efree_idx_reg;
    assign inc_count  = !ehit_reg ? 32'd1
                      : (ecount_reg == 32'hFFFF_FFFF) ? ecount_reg : ecount_reg + 32'd1;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            id_reg    <= s_tdata[63:0];
            addr_reg  <= s_tdata[127:64];
            bin_reg   <= s_tdata[136:128];
            op_reg    <= s_tuser[0];
            major_reg <= s_tuser[1];
        end
        if (cmd.ent_step) rd_reg <= entry_mem[eidx_reg];
        if (cmd.commit) begin
            entry_mem[wr_idx]  <= '{addr: addr_reg, owner: cur_slot, count: inc_count};
            newcnt_reg         <= inc_count;
            if (!ohit_reg) owner_key_reg[ofree_slot_reg] <= id_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            owner_valid_reg <= '0;
            entry_valid_reg <= '0;
            pval_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cmd.load) begin
                oidx_reg  <= '0;
                ohit_reg  <= 1'b0;
                ofree_reg <= 1'b0;
                eidx_reg  <= '0;
                ehit_reg  <= 1'b0;
                efree_reg <= 1'b0;
                acc_reg   <= '0;
                rep_reg   <= 1'b0;
            end
            if (cmd.own_step) begin
                oidx_reg <= oidx_reg + 1'b1;
                if (owner_valid_reg[oidx_reg] && owner_key_reg[oidx_reg] == id_reg) begin
                    ohit_reg  <= 1'b1;
                    oslot_reg <= oidx_reg;
                end
                if (!owner_valid_reg[oidx_reg] && !ofree_reg) begin
                    ofree_reg      <= 1'b1;
                    ofree_slot_reg <= oidx_reg;
                end
            end
            pval_reg <= cmd.ent_step;
            if (cmd.ent_step) begin
                eidx_reg   <= eidx_reg + 1'b1;
                pidx_reg   <= eidx_reg;
                pvalid_reg <= entry_valid_reg[eidx_reg];
            end
            // Compare stage, in the cycle after the memory read.
            if (pval_reg) begin
                if (addr_match) begin
                    ehit_reg     <= 1'b1;
                    ehit_idx_reg <= pidx_reg;
                    ecount_reg   <= rd_reg.count;
                end
                if (!pvalid_reg && !efree_reg) begin
                    efree_reg     <= 1'b1;
                    efree_idx_reg <= pidx_reg;
                end
                if (own_match && bin_match) acc_reg <= acc_reg + 1'b1;
                if (own_match && rd_reg.count >= 32'd2) rep_reg <= 1'b1;
            end
            if (cmd.commit) begin
                entry_valid_reg[wr_idx] <= 1'b1;
                if (!ohit_reg) owner_valid_reg[ofree_slot_reg] <= 1'b1;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_user_reg <= cmd.status;
            out_data_reg <= '0;
            if (cmd.status == rft_pkg::ST_COUNTED) begin
                out_data_reg[31:0] <= newcnt_reg;
                out_data_reg[32]   <= !ohit_reg;
                out_data_reg[33]   <= !ehit_reg;
            end else if (cmd.status == rft_pkg::ST_QUERY_OK) begin
                out_data_reg[65:34] <= 32'(acc_reg);
                out_data_reg[66]    <= rep_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    assign sts.is_query = (op_reg == rft_pkg::OP_QUERY);
    assign sts.is_major = major_reg;
    assign sts.own_last = (oidx_reg == OWN_LAST);
    assign sts.own_hit  = ohit_reg;
    assign sts.own_free = ofree_reg;
    assign sts.ent_last = (eidx_reg == ENT_LAST);
    assign sts.ent_hit  = ehit_reg;
    assign sts.ent_free = efree_reg;
    assign sts.out_free = !out_valid_reg || m_tready;

    `RFT_ASSERT_IMP(a_commit_target, aclk, aresetn, cmd.commit, (ohit_reg || ofree_reg) && (ehit_reg || efree_reg), "commit without a target slot")
    `RFT_ASSERT_IMP(a_no_overwrite, aclk, aresetn, cmd.out_load, !out_valid_reg || m_tready, "result overwritten while stalled")
    `RFT_ASSERT_NXT(a_count_nonzero, aclk, aresetn, cmd.commit, newcnt_reg != 32'd0, "committed count is zero")

endmodule

FILE: tb/refault_frequency_checker.sv
`timescale 1ns / 1ps
// Result checker for the refault frequency tracker: mirrors the owner, entry and
// histogram tables, predicts each result and compares it. Depends on rft_pkg.
module refault_frequency_checker
    import rft_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [143:0] s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [71:0]  m_tdata,
    input  logic [2:0]   m_tuser,
    output int           fail_count,
    output int           pending
);

    typedef struct {
        status_t     status;
        logic [31:0] new_count;
        logic        owner_created;
        logic        address_created;
        logic [31:0] bin_value;
        logic        has_repeats;
    } tracker_result_t;

    logic [63:0] own_key [OWNER_SLOTS];
    bit          own_ok  [OWNER_SLOTS];
    logic [63:0] ent_addr[ADDRESS_ENTRIES];
    int unsigned ent_own [ADDRESS_ENTRIES];
    logic [31:0] ent_cnt [ADDRESS_ENTRIES];
    bit          ent_ok  [ADDRESS_ENTRIES];
    int unsigned hist    [OWNER_SLOTS][COUNT_LIMIT + 1];

    tracker_result_t expected_results[$];

    function automatic int owner_slot_of(logic [63:0] key);
        for (int s = 0; s < OWNER_SLOTS; s++)
            if (own_ok[s] && own_key[s] == key) return s;
        return -1;
    endfunction

    // Updates the mirrored tables and returns the result this request must give.
    function automatic tracker_result_t track_refault(logic op, logic [63:0] id,
                                                      logic [63:0] addr, logic major,
                                                      logic [8:0] bidx);
        tracker_result_t r;
        int slot, e, s;
        bit new_owner;
        bit new_entry;
        logic [31:0] old;
        r = '{ST_COUNTED, 32'd0, 1'b0, 1'b0, 32'd0, 1'b0};
        new_owner = 0;
        new_entry = 0;
        slot = owner_slot_of(id);
        if (op == OP_QUERY) begin
            if (slot < 0) begin
                r.status = ST_OWNER_UNKNOWN;
                return r;
            end
            r.status = ST_QUERY_OK;
            if (bidx <= COUNT_LIMIT) r.bin_value = hist[slot][bidx];
            for (int c = 2; c <= COUNT_LIMIT; c++)
                if (hist[slot][c] != 0) r.has_repeats = 1'b1;
            return r;
        end
        if (!major) begin
            r.status = ST_IGNORED;
            return r;
        end
        if (slot < 0) begin
            for (s = 0; s < OWNER_SLOTS; s++)
                if (!own_ok[s]) break;
            if (s >= OWNER_SLOTS) begin
                r.status = ST_OWNER_FULL;
                return r;
            end
            slot = s;
            new_owner = 1;
        end
        e = -1;
        if (!new_owner)
            for (int i = 0; i < ADDRESS_ENTRIES; i++)
                if (e < 0 && ent_ok[i] && ent_own[i] == slot && ent_addr[i] == addr) e = i;
        if (e < 0) begin
            for (e = 0; e < ADDRESS_ENTRIES; e++)
                if (!ent_ok[e]) break;
            if (e >= ADDRESS_ENTRIES) begin
                // Nothing is allocated, not even the new owner.
                r.status = ST_ADDR_FULL;
                return r;
            end
            new_entry = 1;
        end
        if (new_owner) begin
            own_ok[slot]  = 1;
            own_key[slot] = id;
        end
        if (new_entry) begin
            ent_ok[e]   = 1;
            ent_addr[e] = addr;
            ent_own[e]  = slot;
            ent_cnt[e]  = 32'd1;
            hist[slot][1]++;
        end else if (ent_cnt[e] != 32'hFFFF_FFFF) begin
            old = ent_cnt[e];
            ent_cnt[e] = old + 1;
            // Addresses already in the top bin stay there untouched.
            if (old < COUNT_LIMIT) begin
                hist[slot][old]--;
                hist[slot][(old + 1 < COUNT_LIMIT) ? old + 1 : COUNT_LIMIT]++;
            end
        end
        r.new_count       = ent_cnt[e];
        r.owner_created   = new_owner;
        r.address_created = new_entry;
        return r;
    endfunction

    function automatic void check_field(string name, longint unsigned exp_v,
                                        longint unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge aclk) begin
        tracker_result_t exp_r;
        if (!aresetn) begin
            for (int s = 0; s < OWNER_SLOTS; s++) begin
                own_ok[s] = 0;
                for (int c = 0; c <= COUNT_LIMIT; c++) hist[s][c] = 0;
            end
            for (int i = 0; i < ADDRESS_ENTRIES; i++) ent_ok[i] = 0;
            expected_results.delete();
        end else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(track_refault(s_tuser[0], s_tdata[63:0],
                                                         s_tdata[127:64], s_tuser[1],
                                                         s_tdata[136:128]));
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    fail_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    check_field("status", exp_r.status, m_tuser);
                    check_field("new_count", exp_r.new_count, m_tdata[31:0]);
                    check_field("owner_created", exp_r.owner_created, m_tdata[32]);
                    check_field("address_created", exp_r.address_created, m_tdata[33]);
                    check_field("bin_value", exp_r.bin_value, m_tdata[65:34]);
                    check_field("has_repeats", exp_r.has_repeats, m_tdata[66]);
                end
            end
        end
        pending <= expected_results.size();
    end

endmodule

FILE: tb/tb_refault_frequency_tracker.sv
`timescale 1ns / 1ps
// Testbench top for the refault frequency tracker: clock, reset, request stimulus
// and verdict. Depends on rft_pkg, refault_frequency_tracker and the checker.
module tb_refault_frequency_tracker;
    import rft_pkg::*;

    localparam int RUN_LIMIT = 1_500_000;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [143:0] s_tdata;   // owner_id[63:0], page_addr[127:64], bin_index[136:128]
    logic [1:0]   s_tuser;   // opcode[0], is_major[1]
    logic         m_tvalid;
    logic         m_tready;
    logic [71:0]  m_tdata;   // new_count[31:0], owner_created[32], address_created[33],
                             // bin_value[65:34], has_repeats[66]
    logic [2:0]   m_tuser;   // status[2:0]

    int fail_count;
    int pending;
    int sender_idle_pct;
    int receiver_idle_pct;
    int cycle_count;

    refault_frequency_tracker dut (.*);

    // The checker watches both channels and keeps its own copy of the tables.
    refault_frequency_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // The receiver stalls at random at the rate of the current phase.
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= receiver_idle_pct);

    // Guard against a hang: a correct run ends far earlier than this.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("** refault_frequency_tracker: FAILED **");
            $finish;
        end
    end

    // Offers one request and holds it until the block takes it. s_tvalid is
    // left high afterward, so back-to-back requests never lower and raise it
    // within the same time step.
    task automatic send_request(logic op, logic [63:0] id, logic [63:0] addr,
                                logic major, logic [8:0] bidx);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, bidx, addr, id};
        s_tuser  <= {major, op};
        do @(posedge aclk); while (!s_tready);
    endtask

    initial begin
        logic [63:0] owner_pool[20];
        logic [63:0] addr_pool[8];
        logic [63:0] id;
        logic [63:0] addr;
        logic [8:0]  bidx;
        int          pick;

        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cycle_count = 0;
        sender_idle_pct = 0;
        receiver_idle_pct = 0;

        // Owner zero is the hot owner and gets a slot in the directed part.
        owner_pool[0] = 64'd0;
        owner_pool[1] = '1;
        for (int i = 2; i < 20; i++) owner_pool[i] = {$urandom, $urandom};
        for (int i = 0; i < 8; i++) addr_pool[i] = {$urandom, $urandom};

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: unknown owner, minor faults, field extremes, and
        // queries of bins inside and above the histogram range.
        send_request(OP_QUERY, 64'd0, 64'd0, 1'b0, 9'd0);
        send_request(OP_RECORD, '1, '1, 1'b0, 9'd0);
        send_request(OP_RECORD, 64'd0, 64'd0, 1'b1, 9'd0);
        send_request(OP_RECORD, 64'd0, 64'd0, 1'b1, '1);
        send_request(OP_RECORD, '1, '1, 1'b1, 9'd0);
        send_request(OP_RECORD, '1, 64'd0, 1'b1, 9'd0);
        send_request(OP_RECORD, 64'd0, '1, 1'b0, 9'd0);
        send_request(OP_QUERY, 64'd0, 64'd0, 1'b0, 9'd1);
        send_request(OP_QUERY, 64'd0, '1, 1'b1, 9'd2);
        send_request(OP_QUERY, '1, 64'd0, 1'b0, 9'd1);
        send_request(OP_QUERY, '1, 64'd0, 1'b0, 9'd256);
        send_request(OP_QUERY, 64'd0, 64'd0, 1'b0, 9'd257);
        send_request(OP_QUERY, 64'd0, 64'd0, 1'b0, 9'd511);
        send_request(OP_QUERY, 64'h8000_0000_0000_0000, 64'd0, 1'b0, 9'd0);

        // Random part in three phases of idling. The largest share of the records
        // hammer one hot address so that its count passes the top bin; the others reuse
        // a small address set or take fresh addresses until the entry table fills.
        // Twenty owners exceed the sixteen owner slots.
        for (int ph = 0; ph < 3; ph++) begin
            sender_idle_pct   = (ph == 0) ? 24 : (ph == 1) ? 56 : 0;
            receiver_idle_pct = (ph == 0) ? 56 : (ph == 1) ? 24 : 0;
            for (int n = 0; n < 300; n++) begin
                pick = $urandom_range(99);
                id   = owner_pool[$urandom_range(19)];
                addr = {$urandom, $urandom};
                case ($urandom_range(4))
                    0, 1:    bidx = 9'($urandom_range(4));
                    2:       bidx = 9'd256;
                    default: bidx = 9'($urandom_range(511));
                endcase
                if (pick < 15) begin
                    if ($urandom_range(9) == 0) id = {$urandom, $urandom};
                    send_request(OP_QUERY, id, addr, 1'($urandom_range(1)), bidx);
                end else if (pick < 20) begin
                    send_request(OP_RECORD, id, addr, 1'b0, bidx);
                end else if (pick < 55) begin
                    send_request(OP_RECORD, 64'd0, 64'd0, 1'b1, bidx);
                end else if (pick < 78) begin
                    send_request(OP_RECORD, id, addr_pool[$urandom_range(7)], 1'b1, bidx);
                end else begin
                    send_request(OP_RECORD, id, addr, 1'b1, bidx);
                end
            end
        end
        s_tvalid <= 1'b0;

        repeat (2) @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("** refault_frequency_tracker: PASSED **");
        end else begin
            $display("** refault_frequency_tracker: FAILED **");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/rft_pkg.sv
rtl/rft_ctrl.sv
rtl/rft_datapath.sv
rtl/refault_frequency_tracker.sv
tb/refault_frequency_checker.sv
tb/tb_refault_frequency_tracker.sv
